FILE: sv/sfp_pkg.sv
// Shared types, character constants and digit helpers for the status frame parser.
// No dependencies; imported by sfp_decode and status_frame_parser_top.
package sfp_pkg;

    localparam int C_KEEP = 5;

    localparam logic [7:0] C_END_CHAR = 8'h24;   // '$'
    localparam logic [7:0] C_HEAD_C   = 8'h43;   // 'C'
    localparam logic [7:0] C_HEAD_U   = 8'h55;   // 'U'
    localparam logic [7:0] C_HEAD_V   = 8'h56;   // 'V'

    localparam logic [2:0] C_LEN_MAX  = 3'd7;
    localparam logic [2:0] C_LEN_CU   = 3'd5;
    localparam logic [2:0] C_LEN_V    = 3'd4;

    typedef enum logic [1:0] {
        EV_NONE    = 2'd0,
        EV_PRESS   = 2'd1,
        EV_RELEASE = 2'd2
    } t_event;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } t_digit;

    // Frame and sensor state carried from word to word.
    typedef struct packed {
        logic [C_KEEP-1:0][7:0] chars;
        logic [2:0]             len;
        logic [1:0]             flags;
        logic [13:0]            volt;
        logic                   ver;
        logic [7:0]             key;
        logic                   press;
    } t_state;

    typedef struct packed {
        logic        obstacle_one;
        logic        obstacle_two;
        logic [13:0] battery_mv;
        logic        version_seen;
        t_event      event_kind;
        logic [7:0]  key_code;
    } t_result;

    function automatic t_digit hex_digit(input logic [7:0] c);
        t_digit d;
        d.ok  = 1'b1;
        d.val = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            d.val = 4'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            d.val = 4'(c - 8'h57);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            d.val = 4'(c - 8'h37);
        end else begin
            d.ok = 1'b0;
        end
        return d;
    endfunction

    function automatic t_digit dec_digit(input logic [7:0] c);
        t_digit d;
        d.ok  = (c >= 8'h30 && c <= 8'h39);
        d.val = 4'(c - 8'h30);
        return d;
    endfunction

endpackage

FILE: sv/sfp_decode.sv
// Single-pass frame logic: appends a character or decodes the finished frame.
// Depends on sfp_pkg.
module sfp_decode
    import sfp_pkg::*;
(
    input  logic [7:0] i_byte,
    input  t_state     i_state,
    output t_state     o_state,
    output t_result    o_result
);

    t_digit      f1, f2, k1, k2;
    t_digit      u1, u2, u3, u4;
    logic [7:0]  key;
    logic [13:0] volt;
    t_event      kind;
    logic [7:0]  code;

    always_comb begin
        f1 = hex_digit(i_state.chars[1]);
        f2 = hex_digit(i_state.chars[2]);
        k1 = hex_digit(i_state.chars[3]);
        k2 = hex_digit(i_state.chars[4]);
        u1 = dec_digit(i_state.chars[1]);
        u2 = dec_digit(i_state.chars[2]);
        u3 = dec_digit(i_state.chars[3]);
        u4 = dec_digit(i_state.chars[4]);
        key  = {k1.val, k2.val};
        volt = 14'(u1.val) * 14'd1000 + 14'(u2.val) * 14'd100
             + 14'(u3.val) * 14'd10 + 14'(u4.val);
    end

    always_comb begin
        o_state = i_state;
        kind    = EV_NONE;
        code    = 8'd0;
        if (i_byte == C_END_CHAR) begin
            if (i_state.len == C_LEN_CU && i_state.chars[0] == C_HEAD_C) begin
                if (f1.ok && f2.ok) begin
                    o_state.flags = {(f2.val == 4'd0), (f1.val == 4'd0)};
                end
                if (k1.ok && k2.ok) begin
                    if (key == 8'd0) begin
                        if (i_state.key != 8'd0) begin
                            kind = EV_RELEASE;
                        end
                        o_state.press = 1'b0;
                        o_state.key   = 8'd0;
                    end else if (key != i_state.key) begin
                        // only the first press until a zero key is reported
                        if (!i_state.press) begin
                            kind          = EV_PRESS;
                            code          = key;
                            o_state.press = 1'b1;
                        end
                        o_state.key = key;
                    end
                end
            end else if (i_state.len == C_LEN_CU && i_state.chars[0] == C_HEAD_U) begin
                if (u1.ok && u2.ok && u3.ok && u4.ok) begin
                    o_state.volt = volt;
                end
            end else if (i_state.len == C_LEN_V && i_state.chars[0] == C_HEAD_V) begin
                o_state.ver = 1'b1;
            end
            o_state.len = 3'd0;
        end else begin
            for (int i = 0; i < C_KEEP; i++) begin
                if (i_state.len == 3'(i)) begin
                    o_state.chars[i] = i_byte;
                end
            end
            if (i_state.len != C_LEN_MAX) begin
                o_state.len = i_state.len + 3'd1;
            end
        end
    end

    always_comb begin
        o_result.obstacle_one = o_state.flags[0];
        o_result.obstacle_two = o_state.flags[1];
        o_result.battery_mv   = o_state.volt;
        o_result.version_seen = o_state.ver;
        o_result.event_kind   = kind;
        o_result.key_code     = code;
    end

endmodule

FILE: sv/status_frame_parser_top.sv
// Status frame parser top level: input word register, decode, result register.
// A result word passes the input register, then the result register, and is
// held there while the output stalls. Throughput: one byte per cycle unless
// the output stalls; the decode is a single combinational pass.
// Reset (synchronous, active low) clears both valid flags and all decoded
// state; the five kept frame characters are not reset and need no clearing.
// Depends on sfp_pkg and sfp_decode.
module status_frame_parser_top
    import sfp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_rx_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_obstacle_one,
    output logic        o_obstacle_two,
    output logic [13:0] o_battery_mv,
    output logic        o_version_seen,
    output logic [1:0]  o_event_kind,
    output logic [7:0]  o_key_code
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    t_result    r_result;
    t_state     r_state;
    t_state     n_state;
    t_result    n_result;
    logic       out_free;
    logic       advance;
    logic       take_in;

    assign out_free = !r_out_valid || !i_out_stall;
    assign advance  = r_in_valid && out_free;
    assign take_in  = i_in_valid && !o_in_stall;
    assign o_in_stall = r_in_valid && !out_free;

    sfp_decode u_decode (
        .i_byte   (r_in_byte),
        .i_state  (r_state),
        .o_state  (n_state),
        .o_result (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (!r_in_valid || out_free) begin
                r_in_valid <= i_in_valid;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_in) begin
            r_in_byte <= i_rx_byte;
        end
        if (advance) begin
            r_result      <= n_result;
            r_state.chars <= n_state.chars;
        end
        if (!i_rst_n) begin
            r_state.len   <= 3'd0;
            r_state.flags <= 2'd0;
            r_state.volt  <= 14'd0;
            r_state.ver   <= 1'b0;
            r_state.key   <= 8'd0;
            r_state.press <= 1'b0;
        end else if (advance) begin
            r_state.len   <= n_state.len;
            r_state.flags <= n_state.flags;
            r_state.volt  <= n_state.volt;
            r_state.ver   <= n_state.ver;
            r_state.key   <= n_state.key;
            r_state.press <= n_state.press;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_obstacle_one = r_result.obstacle_one;
    assign o_obstacle_two = r_result.obstacle_two;
    assign o_battery_mv   = r_result.battery_mv;
    assign o_version_seen = r_result.version_seen;
    assign o_event_kind   = r_result.event_kind;
    assign o_key_code     = r_result.key_code;

endmodule
